FILE: sv/key_combo_sequence_detector_defines.svh
// ----------------------------------------------------------------------------
// Key combination detector assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef KEY_COMBO_SEQUENCE_DETECTOR_DEFINES_SVH
`define KEY_COMBO_SEQUENCE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kcsd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kcsd: next-cycle check failed");

`endif

FILE: sv/kcsd_pkg.sv
// ----------------------------------------------------------------------------
// Key combination detector package
// Widths, input modes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package kcsd_pkg;

	localparam int KEY_W  = 10;
	localparam int RUN_W  = 4;
	localparam int WIN_W  = 16;
	localparam int CNT_W  = 7;
	localparam int TICK_W = 32;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 16;

	// Kind of input item.
	typedef enum logic [1:0] {
		MODE_KEY   = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_TRIGGER_KEY    = 3'd0,
		REG_FIRST_TAP_KEY  = 3'd1,
		REG_SECOND_TAP_KEY = 3'd2,
		REG_FIRST_RUN      = 3'd3,
		REG_SECOND_RUN     = 3'd4,
		REG_THIRD_RUN      = 3'd5,
		REG_WINDOW_TICKS   = 3'd6
	} reg_idx_t;

	// Configuration register file.
	typedef struct packed {
		logic [KEY_W-1:0] trigger_key;
		logic [KEY_W-1:0] first_tap_key;
		logic [KEY_W-1:0] second_tap_key;
		logic [RUN_W-1:0] first_run;
		logic [RUN_W-1:0] second_run;
		logic [RUN_W-1:0] third_run;
		logic [WIN_W-1:0] window_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		trigger_key:    10'd114,
		first_tap_key:  10'd116,
		second_tap_key: 10'd115,
		first_run:      4'd9,
		second_run:     4'd5,
		third_run:      4'd3,
		window_ticks:   16'd1900
	};

endpackage

`default_nettype wire

FILE: sv/key_combo_sequence_detector.sv
// ----------------------------------------------------------------------------
// Key combination detector
// Matches a trigger press followed by three runs of key taps, rate-checked
// against a tick window, and keeps a sticky trigger flag.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_stall) carries key events, time ticks
//   and clear requests. Every accepted item produces exactly one result on
//   the result channel (result_valid/result_stall): the sticky fired flag and
//   the number of pattern events matched so far.
//   An item is registered at acceptance and evaluated by a single pass of
//   logic from the input register into the result register. One item is
//   taken every cycle while the receiver does not stall; the 32-bit window
//   compare is the longest path.
//   When the receiver stalls, the result register holds; one more item can
//   wait in the input register, after which item_stall is raised.
//   Reset loads the default pattern and clears all progress, window and
//   trigger state. cfg_ready is always high; the user must write registers
//   only while no items are in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module key_combo_sequence_detector
	import kcsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write channel.
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	// Item channel.
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [1:0]        mode,
	input  wire logic [KEY_W-1:0]  key_code,
	input  wire logic              key_down,
	// Result channel.
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   fired,
	output logic [CNT_W-1:0]       progress
);

	cfg_t              cfg_q;

	logic              item_valid_s1;
	mode_t             mode_s1;
	logic [KEY_W-1:0]  key_code_s1;
	logic              key_down_s1;

	logic              result_valid_s2;
	logic              fired_s2;
	logic [CNT_W-1:0]  progress_s2;

	logic [CNT_W-1:0]  match_count_q;
	logic [TICK_W-1:0] tick_now_q;
	logic [TICK_W-1:0] window_start_q;
	logic              window_begun_q;
	logic [CNT_W-1:0]  window_count_q;
	logic              fired_latch_q;

	logic [CNT_W-1:0]  match_count_n;
	logic [TICK_W-1:0] tick_now_n;
	logic [TICK_W-1:0] window_start_n;
	logic              window_begun_n;
	logic [CNT_W-1:0]  window_count_n;
	logic              fired_latch_n;

	logic              s1_advance;
	logic [5:0]        run_sum;
	logic [5:0]        first_second_sum;
	logic [CNT_W-1:0]  pat_len;
	logic [CNT_W-1:0]  burst;
	logic              key_used;
	logic [CNT_W-1:0]  step_idx;
	logic [5:0]        tap_idx;
	logic [KEY_W-1:0]  exp_key;
	logic              exp_down;
	logic [CNT_W-1:0]  match_inc;
	logic [TICK_W-1:0] win_start_eff;
	logic [TICK_W-1:0] win_end;
	logic [TICK_W-1:0] win_diff;
	logic              win_expired;
	logic [TICK_W-1:0] win_start_next;
	logic [CNT_W-1:0]  win_count_eff;
	logic              win_pass;

	// Handshakes: the input register moves on when the result register is free.
	assign cfg_ready    = 1'b1;
	assign s1_advance   = item_valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall   = item_valid_s1 && !s1_advance;
	assign result_valid = result_valid_s2;
	assign fired        = fired_s2;
	assign progress     = progress_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TRIGGER_KEY:    cfg_q.trigger_key    <= cfg_data[KEY_W-1:0];
				REG_FIRST_TAP_KEY:  cfg_q.first_tap_key  <= cfg_data[KEY_W-1:0];
				REG_SECOND_TAP_KEY: cfg_q.second_tap_key <= cfg_data[KEY_W-1:0];
				REG_FIRST_RUN:      cfg_q.first_run      <= cfg_data[RUN_W-1:0];
				REG_SECOND_RUN:     cfg_q.second_run     <= cfg_data[RUN_W-1:0];
				REG_THIRD_RUN:      cfg_q.third_run      <= cfg_data[RUN_W-1:0];
				REG_WINDOW_TICKS:   cfg_q.window_ticks   <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mode_s1     <= mode_t'(mode);
			key_code_s1 <= key_code;
			key_down_s1 <= key_down;
		end
	end

	// Pattern geometry and the event expected at the current position.
	assign run_sum          = 6'({2'b0, cfg_q.first_run}) + 6'({2'b0, cfg_q.second_run})
	                        + 6'({2'b0, cfg_q.third_run});
	assign first_second_sum = 6'({2'b0, cfg_q.first_run}) + 6'({2'b0, cfg_q.second_run});
	assign burst            = {run_sum, 1'b0};
	assign pat_len          = burst + 7'd1;
	assign key_used         = (key_code_s1 == cfg_q.trigger_key)
	                        || (key_code_s1 == cfg_q.first_tap_key
	                            && (cfg_q.first_run != '0 || cfg_q.third_run != '0))
	                        || (key_code_s1 == cfg_q.second_tap_key
	                            && cfg_q.second_run != '0);
	assign step_idx         = match_count_q - 7'd1;
	assign tap_idx          = step_idx[CNT_W-1:1];
	assign exp_down         = (match_count_q == '0) ? 1'b1 : !step_idx[0];
	assign match_inc        = match_count_q + 7'd1;

	always_comb begin
		if (match_count_q == '0) begin
			exp_key = cfg_q.trigger_key;
		end else if (tap_idx < {2'b0, cfg_q.first_run}) begin
			exp_key = cfg_q.first_tap_key;
		end else if (tap_idx < first_second_sum) begin
			exp_key = cfg_q.second_tap_key;
		end else begin
			exp_key = cfg_q.first_tap_key;
		end
	end

	// Rate window: restart when the tick count has passed the window end.
	assign win_start_eff  = window_begun_q ? window_start_q : tick_now_q;
	assign win_end        = win_start_eff + {16'b0, cfg_q.window_ticks};
	assign win_diff       = tick_now_q - win_end;
	assign win_expired    = (win_diff != '0) && !win_diff[TICK_W-1];
	assign win_start_next = win_expired ? tick_now_q : win_start_eff;
	assign win_count_eff  = win_expired ? '0 : window_count_q;
	assign win_pass       = (burst != '0) && (burst > win_count_eff);

	// Next state for the item in the input register.
	always_comb begin
		match_count_n  = match_count_q;
		tick_now_n     = tick_now_q;
		window_start_n = window_start_q;
		window_begun_n = window_begun_q;
		window_count_n = window_count_q;
		fired_latch_n  = fired_latch_q;
		case (mode_s1)
			MODE_KEY: begin
				if (key_used) begin
					if (match_count_q >= pat_len) begin
						match_count_n = '0;
					end else if (key_code_s1 != exp_key || key_down_s1 != exp_down) begin
						match_count_n = '0;
					end else begin
						match_count_n = match_inc;
						if (cfg_q.window_ticks == '0) begin
							if (match_inc == pat_len) begin
								fired_latch_n = 1'b1;
							end
						end else begin
							window_begun_n = 1'b1;
							window_start_n = win_start_next;
							if (win_pass) begin
								window_count_n = win_count_eff + 7'd1;
							end else begin
								window_count_n = win_count_eff;
								if (match_inc == pat_len) begin
									fired_latch_n = 1'b1;
								end else begin
									match_count_n = '0;
								end
							end
						end
					end
				end
			end
			MODE_TICK: begin
				tick_now_n = tick_now_q + 32'd1;
			end
			MODE_CLEAR: begin
				match_count_n = '0;
			end
			default: begin
			end
		endcase
	end

	// Detector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q  <= '0;
			tick_now_q     <= '0;
			window_start_q <= '0;
			window_begun_q <= 1'b0;
			window_count_q <= '0;
			fired_latch_q  <= 1'b0;
		end else if (s1_advance) begin
			match_count_q  <= match_count_n;
			tick_now_q     <= tick_now_n;
			window_start_q <= window_start_n;
			window_begun_q <= window_begun_n;
			window_count_q <= window_count_n;
			fired_latch_q  <= fired_latch_n;
		end
	end

	// Result register: loads a new result, holds while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
			fired_s2        <= 1'b0;
			progress_s2     <= '0;
		end else if (s1_advance) begin
			result_valid_s2 <= 1'b1;
			fired_s2        <= fired_latch_n;
			progress_s2     <= match_count_n;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: sv/kcsd_checker.sv
// ----------------------------------------------------------------------------
// Key combination detector checker
// Port-level properties of the detector, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_combo_sequence_detector_defines.svh"

module kcsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic        fired,
	input wire logic [6:0]  progress
);

	// A stalled result keeps its payload.
	`KCSD_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(fired) && $stable(progress))

	// The trigger flag never falls once set.
	`KCSD_ASSERT_NEXT(a_fired_sticky, clk, arst_n, fired, fired)

	// The item side only stalls behind a stalled, full result register.
	`KCSD_ASSERT_IMPL(a_stall_cause, clk, arst_n, item_stall, result_valid && result_stall)

	// The trigger can only rise when a new result was loaded.
	`KCSD_ASSERT_IMPL(a_fired_rise, clk, arst_n, $rose(fired), result_valid && $past(!result_valid || !result_stall))

endmodule

bind key_combo_sequence_detector kcsd_checker u_kcsd_checker (.*);

`default_nettype wire
